@@ sv/sorted_key_priority_table_defines.svh @@
`ifndef SORTED_KEY_PRIORITY_TABLE_DEFINES_SVH
`define SORTED_KEY_PRIORITY_TABLE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SKPT_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, disabled during reset
`define SKPT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ sv/skpt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package skpt_pkg;

    localparam int unsigned ENTRIES_DEF  = 16;
    localparam int unsigned KEY_BITS_DEF = 32;
    localparam int unsigned TAG_BITS_DEF = 64;

    localparam int unsigned CMD_W      = 3;
    localparam int unsigned STATUS_W   = 2;
    localparam int unsigned COUNT_W    = 5;
    localparam int unsigned TAG_PORT_W = 64;
    localparam int unsigned KEY_PORT_W = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD,
        CMD_POP,
        CMD_PEEK,
        CMD_DELETE,
        CMD_UPSERT,
        CMD_REKEY,
        CMD_KEY_OF_TAG,
        CMD_TAG_OF_KEY
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK,
        STAT_MISS,
        STAT_FULL
    } status_t;

    // what a scan compare looks for
    typedef enum logic [1:0] {
        MATCH_ANY,
        MATCH_TAG,
        MATCH_KEY,
        MATCH_POS
    } match_t;

    typedef enum logic [2:0] {
        PTR_HOLD,
        PTR_ZERO,
        PTR_INC,
        PTR_DEC,
        PTR_FILL
    } ptr_op_t;

    typedef enum logic [1:0] {
        RD_PTR,
        RD_NEXT,
        RD_PREV
    } rd_sel_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_SHIFT,
        WR_INPUT,
        WR_FOUND
    } wr_src_t;

    typedef enum logic [1:0] {
        FILL_HOLD,
        FILL_INC,
        FILL_DEC
    } fill_op_t;

    typedef enum logic [1:0] {
        RES_ZERO,
        RES_FOUND,
        RES_INPUT,
        RES_REKEY
    } res_sel_t;

    typedef struct packed {
        logic     load;
        match_t   match_sel;
        ptr_op_t  ptr_op;
        rd_sel_t  rd_sel;
        logic     pos_save;
        logic     hit_save;
        wr_src_t  wr_src;
        fill_op_t fill_op;
        logic     out_load;
        status_t  out_status;
        res_sel_t res_sel;
    } dp_ctrl_t;

    typedef struct packed {
        logic scan_end;
        logic match;
        logic rem_end;
        logic ins_end;
        logic full;
        logic empty;
    } dp_stat_t;

endpackage
`default_nettype wire

@@ sv/skpt_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
module skpt_ram
    import skpt_pkg::*;
#(
    parameter int unsigned WIDTH = KEY_BITS_DEF,
    parameter int unsigned DEPTH = ENTRIES_DEF,
    localparam int unsigned AW   = $clog2(DEPTH)
)
(
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

@@ sv/skpt_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
module skpt_datapath
    import skpt_pkg::*;
#(
    parameter int unsigned ENTRIES  = ENTRIES_DEF,
    parameter int unsigned KEY_BITS = KEY_BITS_DEF,
    parameter int unsigned TAG_BITS = TAG_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [TAG_PORT_W-1:0] item_tag,
    input  wire logic [KEY_PORT_W-1:0] sort_key,
    input  wire dp_ctrl_t              ctrl,
    output dp_stat_t                   stat,
    output logic      [STATUS_W-1:0]   status,
    output logic      [TAG_PORT_W-1:0] result_tag,
    output logic      [KEY_PORT_W-1:0] result_key,
    output logic      [COUNT_W-1:0]    entry_count
);

    localparam int unsigned AW = $clog2(ENTRIES);
    localparam int unsigned PW = $clog2(ENTRIES + 1);

    logic [PW-1:0]       ptr_reg, ptr_next;
    logic [PW-1:0]       pos_reg, pos_next;
    logic [PW-1:0]       fill_reg, fill_next;
    logic [TAG_BITS-1:0] tag_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [TAG_BITS-1:0] found_tag_reg;
    logic [KEY_BITS-1:0] found_key_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [TAG_PORT_W-1:0] rtag_reg;
    logic [KEY_PORT_W-1:0] rkey_reg;
    logic [COUNT_W-1:0]  count_reg;

    logic [PW-1:0]       rd_ptr;
    logic [TAG_BITS-1:0] rd_tag, wr_tag;
    logic [KEY_BITS-1:0] rd_key, wr_key;
    logic                wr_en;

    always_comb
    begin
        case (ctrl.rd_sel)
            RD_NEXT: rd_ptr = ptr_reg + PW'(1);
            RD_PREV: rd_ptr = ptr_reg - PW'(1);
            default: rd_ptr = ptr_reg;
        endcase
    end

    always_comb
    begin
        wr_en  = (ctrl.wr_src != WR_NONE);
        wr_tag = tag_reg;
        wr_key = key_reg;
        case (ctrl.wr_src)
            WR_SHIFT:
            begin
                wr_tag = rd_tag;
                wr_key = rd_key;
            end
            WR_FOUND: wr_tag = found_tag_reg;
            default:  wr_tag = tag_reg;
        endcase
    end

    skpt_ram #(.WIDTH(TAG_BITS), .DEPTH(ENTRIES)) u_tag_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (ptr_reg[AW-1:0]),
        .wdata (wr_tag),
        .raddr (rd_ptr[AW-1:0]),
        .rdata (rd_tag)
    );

    skpt_ram #(.WIDTH(KEY_BITS), .DEPTH(ENTRIES)) u_key_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (ptr_reg[AW-1:0]),
        .wdata (wr_key),
        .raddr (rd_ptr[AW-1:0]),
        .rdata (rd_key)
    );

    always_comb
    begin
        case (ctrl.match_sel)
            MATCH_TAG: stat.match = (rd_tag == tag_reg);
            MATCH_KEY: stat.match = (rd_key == key_reg);
            // insert point: first entry whose key is above the new one
            MATCH_POS: stat.match = (rd_key > key_reg);
            default:   stat.match = 1'b1;
        endcase
        stat.scan_end = (ptr_reg >= fill_reg);
        stat.rem_end  = ((PW+1)'(ptr_reg) + (PW+1)'(1)) >= (PW+1)'(fill_reg);
        stat.ins_end  = (ptr_reg == pos_reg);
        stat.full     = (fill_reg == PW'(ENTRIES));
        stat.empty    = (fill_reg == '0);
    end

    always_comb
    begin
        case (ctrl.ptr_op)
            PTR_ZERO: ptr_next = '0;
            PTR_INC:  ptr_next = ptr_reg + PW'(1);
            PTR_DEC:  ptr_next = ptr_reg - PW'(1);
            PTR_FILL: ptr_next = fill_reg;
            default:  ptr_next = ptr_reg;
        endcase
        if (ctrl.load)
        begin
            ptr_next = '0;
        end
        pos_next = ctrl.pos_save ? ptr_reg : pos_reg;
        case (ctrl.fill_op)
            FILL_INC: fill_next = fill_reg + PW'(1);
            FILL_DEC: fill_next = fill_reg - PW'(1);
            default:  fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg  <= '0;
            pos_reg  <= '0;
            fill_reg <= '0;
        end
        else
        begin
            ptr_reg  <= ptr_next;
            pos_reg  <= pos_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            tag_reg <= TAG_BITS'(item_tag);
            key_reg <= KEY_BITS'(sort_key);
        end
        if (ctrl.hit_save)
        begin
            found_tag_reg <= rd_tag;
            found_key_reg <= rd_key;
        end
        if (ctrl.out_load)
        begin
            status_reg <= ctrl.out_status;
            count_reg  <= COUNT_W'(fill_reg);
            case (ctrl.res_sel)
                RES_FOUND:
                begin
                    rtag_reg <= TAG_PORT_W'(found_tag_reg);
                    rkey_reg <= KEY_PORT_W'(found_key_reg);
                end
                RES_INPUT:
                begin
                    rtag_reg <= TAG_PORT_W'(tag_reg);
                    rkey_reg <= KEY_PORT_W'(key_reg);
                end
                RES_REKEY:
                begin
                    rtag_reg <= TAG_PORT_W'(found_tag_reg);
                    rkey_reg <= KEY_PORT_W'(key_reg);
                end
                default:
                begin
                    rtag_reg <= '0;
                    rkey_reg <= '0;
                end
            endcase
        end
    end

    assign status      = status_reg;
    assign result_tag  = rtag_reg;
    assign result_key  = rkey_reg;
    assign entry_count = count_reg;

endmodule
`default_nettype wire

@@ sv/skpt_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_key_priority_table_defines.svh"
module skpt_ctrl
    import skpt_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire logic [CMD_W-1:0] command,
    output logic                  out_valid,
    input  wire logic             out_stall,
    input  wire dp_stat_t         stat,
    output dp_ctrl_t              ctrl
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_DECIDE,
        S_REM_RD,
        S_REM_WR,
        S_INS_RD,
        S_INS_WR,
        S_DONE
    } state_t;

    state_t  state_reg, state_next;
    cmd_t    cmd_reg, cmd_next;
    match_t  mode_reg, mode_next;
    logic    found_reg, found_next;
    logic    need_ins_reg, need_ins_next;
    status_t status_reg, status_next;
    logic    out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        mode_next      = mode_reg;
        found_next     = found_reg;
        need_ins_next  = need_ins_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg && out_stall;
        ctrl           = '0;
        ctrl.match_sel = mode_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctrl.load     = 1'b1;
                    cmd_next      = cmd_t'(command);
                    found_next    = 1'b0;
                    need_ins_next = 1'b0;
                    status_next   = STAT_OK;
                    state_next    = S_SCAN_RD;
                    unique case (cmd_t'(command)) inside
                        CMD_ADD:
                        begin
                            mode_next = MATCH_POS;
                            if (stat.full)
                            begin
                                status_next = STAT_FULL;
                                state_next  = S_DONE;
                            end
                        end
                        CMD_POP, CMD_PEEK, CMD_REKEY:            mode_next = MATCH_ANY;
                        CMD_DELETE, CMD_UPSERT, CMD_KEY_OF_TAG:  mode_next = MATCH_TAG;
                        CMD_TAG_OF_KEY:                          mode_next = MATCH_KEY;
                    endcase
                end
            end

            S_SCAN_RD:
            begin
                if (stat.scan_end)
                begin
                    if (mode_reg == MATCH_POS)
                    begin
                        // append at the end: pointer already equals fill
                        ctrl.pos_save = 1'b1;
                        state_next    = S_INS_RD;
                    end
                    else
                    begin
                        found_next = 1'b0;
                        state_next = S_DECIDE;
                    end
                end
                else
                begin
                    ctrl.rd_sel = RD_PTR;
                    state_next  = S_SCAN_CMP;
                end
            end

            S_SCAN_CMP:
            begin
                if (stat.match)
                begin
                    if (mode_reg == MATCH_POS)
                    begin
                        ctrl.pos_save = 1'b1;
                        ctrl.ptr_op   = PTR_FILL;
                        state_next    = S_INS_RD;
                    end
                    else
                    begin
                        ctrl.hit_save = 1'b1;
                        found_next    = 1'b1;
                        state_next    = S_DECIDE;
                    end
                end
                else
                begin
                    ctrl.ptr_op = PTR_INC;
                    state_next  = S_SCAN_RD;
                end
            end

            S_DECIDE:
            begin
                state_next  = S_DONE;
                status_next = found_reg ? STAT_OK : STAT_MISS;
                unique case (cmd_reg) inside
                    CMD_POP, CMD_DELETE:
                    begin
                        if (found_reg)
                        begin
                            state_next = S_REM_RD;
                        end
                    end
                    CMD_UPSERT, CMD_REKEY:
                    begin
                        if (found_reg)
                        begin
                            need_ins_next = 1'b1;
                            state_next    = S_REM_RD;
                        end
                        else if (cmd_reg == CMD_UPSERT)
                        begin
                            if (stat.full)
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                status_next = STAT_OK;
                                ctrl.ptr_op = PTR_ZERO;
                                mode_next   = MATCH_POS;
                                state_next  = S_SCAN_RD;
                            end
                        end
                    end
                    CMD_ADD, CMD_PEEK, CMD_KEY_OF_TAG, CMD_TAG_OF_KEY:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            S_REM_RD:
            begin
                if (stat.rem_end)
                begin
                    ctrl.fill_op = FILL_DEC;
                    if (need_ins_reg)
                    begin
                        ctrl.ptr_op = PTR_ZERO;
                        mode_next   = MATCH_POS;
                        state_next  = S_SCAN_RD;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    ctrl.rd_sel = RD_NEXT;
                    state_next  = S_REM_WR;
                end
            end

            S_REM_WR:
            begin
                ctrl.wr_src = WR_SHIFT;
                ctrl.ptr_op = PTR_INC;
                state_next  = S_REM_RD;
            end

            S_INS_RD:
            begin
                if (stat.ins_end)
                begin
                    ctrl.wr_src  = (cmd_reg == CMD_REKEY) ? WR_FOUND : WR_INPUT;
                    ctrl.fill_op = FILL_INC;
                    state_next   = S_DONE;
                end
                else
                begin
                    ctrl.rd_sel = RD_PREV;
                    state_next  = S_INS_WR;
                end
            end

            S_INS_WR:
            begin
                ctrl.wr_src = WR_SHIFT;
                ctrl.ptr_op = PTR_DEC;
                state_next  = S_INS_RD;
            end

            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    ctrl.out_load   = 1'b1;
                    ctrl.out_status = status_reg;
                    out_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                    if (status_reg != STAT_OK || cmd_reg == CMD_ADD)
                    begin
                        ctrl.res_sel = RES_ZERO;
                    end
                    else if (cmd_reg == CMD_UPSERT)
                    begin
                        ctrl.res_sel = RES_INPUT;
                    end
                    else if (cmd_reg == CMD_REKEY)
                    begin
                        ctrl.res_sel = RES_REKEY;
                    end
                    else
                    begin
                        ctrl.res_sel = RES_FOUND;
                    end
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cmd_reg       <= CMD_ADD;
            mode_reg      <= MATCH_ANY;
            found_reg     <= 1'b0;
            need_ins_reg  <= 1'b0;
            status_reg    <= STAT_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmd_reg       <= cmd_next;
            mode_reg      <= mode_next;
            found_reg     <= found_next;
            need_ins_reg  <= need_ins_next;
            status_reg    <= status_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    `SKPT_ASSERT_NEXT(a_transfer_leaves_idle, state_reg == S_IDLE && in_valid, state_reg != S_IDLE)
    `SKPT_ASSERT_IMPL(a_no_grow_when_full, ctrl.fill_op == FILL_INC, !stat.full)
    `SKPT_ASSERT_IMPL(a_no_shrink_when_empty, ctrl.fill_op == FILL_DEC, !stat.empty)

endmodule
`default_nettype wire

@@ sv/sorted_key_priority_table.sv @@
// Flow: an add to a full table goes straight to the result; an upsert or rekey that
//   hits scans, removes, rescans and shifts the table; a stalled result waits in S_DONE.
// Throughput: one command at a time; each scan or shift step reads, then compares or
//   writes back, on the single read port of the entry memories.
// Reset: fill count cleared at once; entry_count output and entry memories are not
//   cleared, no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module sorted_key_priority_table
    import skpt_pkg::*;
#(
    parameter int unsigned ENTRIES  = ENTRIES_DEF,
    parameter int unsigned KEY_BITS = KEY_BITS_DEF,
    parameter int unsigned TAG_BITS = TAG_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [CMD_W-1:0]      command,
    input  wire logic [TAG_PORT_W-1:0] item_tag,
    input  wire logic [KEY_PORT_W-1:0] sort_key,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic      [STATUS_W-1:0]   status,
    output logic      [TAG_PORT_W-1:0] result_tag,
    output logic      [KEY_PORT_W-1:0] result_key,
    output logic      [COUNT_W-1:0]    entry_count
);

    dp_ctrl_t ctrl;
    dp_stat_t stat;

    skpt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .command   (command),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    skpt_datapath #(
        .ENTRIES  (ENTRIES),
        .KEY_BITS (KEY_BITS),
        .TAG_BITS (TAG_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_tag    (item_tag),
        .sort_key    (sort_key),
        .ctrl        (ctrl),
        .stat        (stat),
        .status      (status),
        .result_tag  (result_tag),
        .result_key  (result_key),
        .entry_count (entry_count)
    );

endmodule
`default_nettype wire
